FILE: hdl/m4i_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4i_pkg: shared types and constants of the 4x4 matrix inverse
// Fixed-point format, rounding shifts and the command/status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package m4i_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int FRAC_BITS   = 16;

   // rounding shifts: cofactor (Q.3F -> Q.F), determinant, inverse element
   localparam int CSH = 2 * FRAC_BITS;
   localparam int DSH = FRAC_BITS;
   localparam int OSH = 62 - FRAC_BITS;

   localparam logic [63:0] ONE_WIDE = 64'd1 << FRAC_BITS;
   localparam logic signed [VALUE_WIDTH-1:0] ONE_VW = ONE_WIDE[VALUE_WIDTH-1:0];
   localparam logic signed [31:0] IDENT_ONE = 32'(ONE_VW);

   localparam logic [63:0] MAXV_WIDE = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;
   localparam logic [31:0] MAXV32    = MAXV_WIDE[31:0];
   localparam logic [63:0] MAX64     = {1'b0, {63{1'b1}}};
   localparam logic [63:0] MIN64     = {1'b1, {63{1'b0}}};

   localparam logic [5:0] DIV_LAST = 6'd62;

   typedef enum logic [1:0] {
      A_MAT,
      A_COF_LO,
      A_COF_HI
   } a_sel_type;

   typedef enum logic [2:0] {
      B_MAT,
      B_MIN_LO,
      B_MIN_HI,
      B_COF_LO,
      B_COF_HI,
      B_REC_LO,
      B_REC_HI
   } b_sel_type;

   typedef enum logic [1:0] {
      RND_COF,
      RND_DET,
      RND_OUT
   } rnd_mode_type;

   typedef struct packed {
      logic         load;
      logic         op_valid;
      a_sel_type    a_sel;
      b_sel_type    b_sel;
      logic         to_minor;
      logic         clr;
      logic         neg;
      logic [3:0]   mat_addr_a;
      logic [3:0]   mat_addr_b;
      logic [3:0]   cof_raddr;
      logic         rnd_valid;
      rnd_mode_type rnd_mode;
      logic [3:0]   cof_waddr;
      logic         div_start;
      logic         out_load;
      logic [1:0]   out_row;
      logic [1:0]   out_col;
      logic         out_last;
   } dp_cmd_type;

   typedef struct packed {
      logic div_busy;
      logic singular;
      logic det_neg;
      logic out_free;
   } dp_sts_type;

endpackage

FILE: hdl/m4i_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4i_req_if: element load channel
// Valid/ready channel carrying one matrix element per beat.
// ----------------------------------------------------------------------------
interface m4i_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         row;
   logic [1:0]         col;
   logic signed [31:0] element_value;
   logic               last;

   modport source (output valid, row, col, element_value, last, input ready);
   modport sink   (input valid, row, col, element_value, last, output ready);
endinterface

FILE: hdl/m4i_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4i_rsp_if: inverse result channel
// Valid/ready channel carrying one inverse element per beat.
// ----------------------------------------------------------------------------
interface m4i_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         out_row;
   logic [1:0]         out_col;
   logic signed [31:0] inverse_value;
   logic               singular;
   logic               saturated;
   logic               out_last;

   modport source (output valid, out_row, out_col, inverse_value, singular, saturated,
                   out_last, input ready);
   modport sink   (input valid, out_row, out_col, inverse_value, singular, saturated,
                   out_last, output ready);
endinterface

FILE: hdl/m4i_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4i_ram: generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module m4i_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

FILE: hdl/m4i_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4i_ctrl: sequencer of the matrix inverse
// Steps the shared multiplier through cofactors, determinant and the sixteen
// output elements, and starts the reciprocal divider between them.
// ----------------------------------------------------------------------------
module m4i_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_last,
   output logic                req_ready,
   output m4i_pkg::dp_cmd_type cmd,
   input  m4i_pkg::dp_sts_type sts
);
   import m4i_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_COF,
      S_DET,
      S_DIV,
      S_OUT
   } state_type;

   localparam logic [4:0] COF_ROUND = 5'd17;
   localparam logic [4:0] DET_ROUND = 5'd10;
   localparam logic [4:0] OUT_ROUND = 5'd6;
   localparam logic [3:0] IDX_LAST  = 4'd15;

   state_type  state_ff;
   logic [4:0] step_ff;
   logic [3:0] idx_ff;

   logic [1:0] ci, cj, k, p, q;
   logic [1:0] r0, r1, r2, cp, cq, ck;
   logic       par;

   function automatic logic [1:0] skip_idx(input logic [1:0] n, input logic [1:0] x);
      skip_idx = (n < x) ? n : n + 2'd1;
   endfunction

   always_comb begin
      ci  = idx_ff[3:2];
      cj  = idx_ff[1:0];
      par = ci[0] ^ cj[0];
      if (step_ff < 5'd5) begin
         k = 2'd0;
      end else if (step_ff < 5'd10) begin
         k = 2'd1;
      end else begin
         k = 2'd2;
      end
      p  = (k == 2'd0) ? 2'd1 : 2'd0;
      q  = (k == 2'd2) ? 2'd1 : 2'd2;
      r0 = skip_idx(2'd0, ci);
      r1 = skip_idx(2'd1, ci);
      r2 = skip_idx(2'd2, ci);
      cp = skip_idx(p, cj);
      cq = skip_idx(q, cj);
      ck = skip_idx(k, cj);
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         S_COF: begin
            case (step_ff) inside
               5'd0, 5'd5, 5'd10: begin
                  cmd.op_valid   = 1'b1;
                  cmd.a_sel      = A_MAT;
                  cmd.b_sel      = B_MAT;
                  cmd.to_minor   = 1'b1;
                  cmd.clr        = 1'b1;
                  cmd.mat_addr_a = {r1, cp};
                  cmd.mat_addr_b = {r2, cq};
               end
               5'd1, 5'd6, 5'd11: begin
                  cmd.op_valid   = 1'b1;
                  cmd.a_sel      = A_MAT;
                  cmd.b_sel      = B_MAT;
                  cmd.to_minor   = 1'b1;
                  cmd.neg        = 1'b1;
                  cmd.mat_addr_a = {r1, cq};
                  cmd.mat_addr_b = {r2, cp};
               end
               5'd3, 5'd8, 5'd13: begin
                  cmd.op_valid   = 1'b1;
                  cmd.a_sel      = A_MAT;
                  cmd.b_sel      = B_MIN_LO;
                  cmd.clr        = (k == 2'd0);
                  cmd.neg        = (k == 2'd1) ^ par;
                  cmd.mat_addr_a = {r0, ck};
               end
               5'd4, 5'd9, 5'd14: begin
                  cmd.op_valid   = 1'b1;
                  cmd.a_sel      = A_MAT;
                  cmd.b_sel      = B_MIN_HI;
                  cmd.neg        = (k == 2'd1) ^ par;
                  cmd.mat_addr_a = {r0, ck};
               end
               COF_ROUND: begin
                  cmd.rnd_valid = 1'b1;
                  cmd.rnd_mode  = RND_COF;
                  cmd.cof_waddr = idx_ff;
               end
               default: begin
               end
            endcase
         end
         S_DET: begin
            if (step_ff < 5'd8) begin
               cmd.op_valid   = 1'b1;
               cmd.a_sel      = A_MAT;
               cmd.b_sel      = step_ff[0] ? B_COF_HI : B_COF_LO;
               cmd.clr        = (step_ff == 5'd0);
               cmd.mat_addr_a = {2'b00, step_ff[2:1]};
               cmd.cof_raddr  = {2'b00, step_ff[2:1]};
            end else if (step_ff == DET_ROUND) begin
               cmd.rnd_valid = 1'b1;
               cmd.rnd_mode  = RND_DET;
            end
         end
         S_DIV: begin
            cmd.div_start = (step_ff == 5'd0);
         end
         S_OUT: begin
            if (step_ff < 5'd4) begin
               cmd.op_valid  = 1'b1;
               cmd.a_sel     = step_ff[1] ? A_COF_HI : A_COF_LO;
               cmd.b_sel     = step_ff[0] ? B_REC_HI : B_REC_LO;
               cmd.clr       = (step_ff == 5'd0);
               // apply the determinant sign to each partial product
               cmd.neg       = sts.det_neg;
               cmd.cof_raddr = {idx_ff[1:0], idx_ff[3:2]};
            end else if (step_ff == OUT_ROUND) begin
               cmd.rnd_valid = 1'b1;
               cmd.rnd_mode  = RND_OUT;
               cmd.out_load  = sts.out_free;
               cmd.out_row   = idx_ff[3:2];
               cmd.out_col   = idx_ff[1:0];
               cmd.out_last  = (idx_ff == IDX_LAST);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
         idx_ff   <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && req_last) begin
                  state_ff <= S_COF;
                  step_ff  <= '0;
                  idx_ff   <= '0;
               end
            end
            S_COF: begin
               if (step_ff == COF_ROUND) begin
                  step_ff <= '0;
                  if (idx_ff == IDX_LAST) begin
                     state_ff <= S_DET;
                  end else begin
                     idx_ff <= idx_ff + 4'd1;
                  end
               end else begin
                  step_ff <= step_ff + 5'd1;
               end
            end
            S_DET: begin
               if (step_ff == DET_ROUND) begin
                  state_ff <= S_DIV;
                  step_ff  <= '0;
               end else begin
                  step_ff <= step_ff + 5'd1;
               end
            end
            S_DIV: begin
               if (step_ff == 5'd0) begin
                  step_ff <= 5'd1;
               end else if (!sts.div_busy) begin
                  state_ff <= S_OUT;
                  idx_ff   <= '0;
                  step_ff  <= sts.singular ? OUT_ROUND : 5'd0;
               end
            end
            S_OUT: begin
               if (step_ff == OUT_ROUND) begin
                  // hold on the round step while the result register is full
                  if (sts.out_free) begin
                     if (idx_ff == IDX_LAST) begin
                        state_ff <= S_IDLE;
                     end else begin
                        idx_ff  <= idx_ff + 4'd1;
                        step_ff <= sts.singular ? OUT_ROUND : 5'd0;
                     end
                  end
               end else begin
                  step_ff <= step_ff + 5'd1;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end
endmodule

FILE: hdl/m4i_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4i_dp: datapath of the matrix inverse
// Element stores, shared 33x33 multiplier with accumulators, rounding and
// saturation, radix-2 reciprocal divider and the result register.
// ----------------------------------------------------------------------------
module m4i_dp (
   input  logic                clock,
   input  logic                reset,
   input  m4i_pkg::dp_cmd_type cmd,
   output m4i_pkg::dp_sts_type sts,
   input  logic [1:0]          req_row,
   input  logic [1:0]          req_col,
   input  logic signed [31:0]  req_element_value,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [1:0]          rsp_out_row,
   output logic [1:0]          rsp_out_col,
   output logic signed [31:0]  rsp_inverse_value,
   output logic                rsp_singular,
   output logic                rsp_saturated,
   output logic                rsp_out_last
);
   import m4i_pkg::*;

   // element stores
   logic signed [VALUE_WIDTH-1:0] elem_vw;
   logic [31:0] elem_sext;
   logic [15:0] valid_ff;
   logic [31:0] mat_a_q, mat_b_q, mat_a, mat_b;
   logic [63:0] cof_q;
   logic        cof_we;

   // multiply pipeline
   logic        p1_valid_ff, p2_valid_ff;
   a_sel_type   p1_a_sel_ff;
   b_sel_type   p1_b_sel_ff;
   logic        p1_to_minor_ff, p1_clr_ff, p1_neg_ff;
   logic [3:0]  p1_addr_a_ff, p1_addr_b_ff;
   logic        p2_to_minor_ff, p2_clr_ff, p2_neg_ff;
   logic [1:0]  p2_sh_ff;
   logic signed [32:0]  opa, opb;
   logic signed [65:0]  prod_ff;
   logic [1:0]          sh;
   logic signed [127:0] term_base, term, addend;
   logic signed [127:0] acc_ff;
   logic [63:0]         minor_ff;

   // rounding
   logic signed [127:0] half, sum, shifted;
   logic        fits64, fitsv;
   logic [63:0] rnd64;
   logic [31:0] rndv;

   // determinant and reciprocal
   logic signed [63:0] det_ff;
   logic [63:0] mag;
   logic [63:0] rem_ff;
   logic [62:0] recip_ff;
   logic [5:0]  div_cnt_ff;
   logic        div_busy_ff;
   logic [64:0] rem_s, rem_d;
   logic        ge;

   // result register
   logic        out_valid_ff;
   logic [1:0]  out_row_ff, out_col_ff;
   logic [31:0] out_value_ff;
   logic        out_sing_ff, out_sat_ff, out_last_ff;

   assign elem_vw   = req_element_value[VALUE_WIDTH-1:0];
   assign elem_sext = 32'(elem_vw);

   m4i_ram #(.WIDTH(32), .DEPTH(16)) u_mat_a (
      .clock(clock), .we(cmd.load), .waddr({req_row, req_col}), .wdata(elem_sext),
      .raddr(cmd.mat_addr_a), .rdata(mat_a_q)
   );

   m4i_ram #(.WIDTH(32), .DEPTH(16)) u_mat_b (
      .clock(clock), .we(cmd.load), .waddr({req_row, req_col}), .wdata(elem_sext),
      .raddr(cmd.mat_addr_b), .rdata(mat_b_q)
   );

   assign cof_we = cmd.rnd_valid && (cmd.rnd_mode == RND_COF);

   m4i_ram #(.WIDTH(64), .DEPTH(16)) u_cof (
      .clock(clock), .we(cof_we), .waddr(cmd.cof_waddr), .wdata(rnd64),
      .raddr(cmd.cof_raddr), .rdata(cof_q)
   );

   // never-loaded elements read as the identity
   always_comb begin
      if (valid_ff[p1_addr_a_ff]) begin
         mat_a = mat_a_q;
      end else begin
         mat_a = (p1_addr_a_ff[3:2] == p1_addr_a_ff[1:0]) ? IDENT_ONE : 32'd0;
      end
      if (valid_ff[p1_addr_b_ff]) begin
         mat_b = mat_b_q;
      end else begin
         mat_b = (p1_addr_b_ff[3:2] == p1_addr_b_ff[1:0]) ? IDENT_ONE : 32'd0;
      end
   end

   always_comb begin
      case (p1_a_sel_ff)
         A_COF_LO: opa = {1'b0, cof_q[31:0]};
         A_COF_HI: opa = {cof_q[63], cof_q[63:32]};
         default:  opa = {mat_a[31], mat_a};
      endcase
      case (p1_b_sel_ff)
         B_MIN_LO: opb = {1'b0, minor_ff[31:0]};
         B_MIN_HI: opb = {minor_ff[63], minor_ff[63:32]};
         B_COF_LO: opb = {1'b0, cof_q[31:0]};
         B_COF_HI: opb = {cof_q[63], cof_q[63:32]};
         B_REC_LO: opb = {1'b0, recip_ff[31:0]};
         B_REC_HI: opb = {2'b00, recip_ff[62:32]};
         default:  opb = {mat_b[31], mat_b};
      endcase
      sh = {1'b0, (p1_a_sel_ff == A_COF_HI)}
         + {1'b0, (p1_b_sel_ff == B_MIN_HI) || (p1_b_sel_ff == B_COF_HI)
                  || (p1_b_sel_ff == B_REC_HI)};
   end

   always_comb begin
      term_base = 128'(prod_ff);
      case (p2_sh_ff)
         2'd0:    term = term_base;
         2'd1:    term = term_base <<< 32;
         default: term = term_base <<< 64;
      endcase
      addend = p2_neg_ff ? -term : term;
   end

   // round to nearest, ties up, then clip
   always_comb begin
      case (cmd.rnd_mode)
         RND_COF: half = 128'sd1 <<< (CSH - 1);
         RND_DET: half = 128'sd1 <<< (DSH - 1);
         default: half = 128'sd1 <<< (OSH - 1);
      endcase
      sum = acc_ff + half;
      case (cmd.rnd_mode)
         RND_COF: shifted = sum >>> CSH;
         RND_DET: shifted = sum >>> DSH;
         default: shifted = sum >>> OSH;
      endcase
      fits64 = (shifted[127:63] == '0) || (shifted[127:63] == '1);
      fitsv  = (shifted[127:VALUE_WIDTH-1] == '0) || (shifted[127:VALUE_WIDTH-1] == '1);
      rnd64  = fits64 ? shifted[63:0] : (shifted[127] ? MIN64 : MAX64);
      rndv   = fitsv ? shifted[31:0] : (shifted[127] ? ~MAXV32 : MAXV32);
   end

   // one quotient bit per cycle of 2^62 / |det|
   always_comb begin
      mag   = det_ff[63] ? (64'd0 - det_ff) : det_ff;
      rem_s = {rem_ff, (div_cnt_ff == 6'd0)};
      ge    = rem_s >= {1'b0, mag};
      rem_d = ge ? (rem_s - {1'b0, mag}) : rem_s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         div_busy_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         det_ff       <= '0;
      end else begin
         if (cmd.load) begin
            valid_ff[{req_row, req_col}] <= 1'b1;
         end
         p1_valid_ff <= cmd.op_valid;
         p2_valid_ff <= p1_valid_ff;
         if (cmd.div_start) begin
            div_busy_ff <= 1'b1;
         end else if (div_busy_ff && (div_cnt_ff == DIV_LAST)) begin
            div_busy_ff <= 1'b0;
         end
         if (cmd.rnd_valid && (cmd.rnd_mode == RND_DET)) begin
            det_ff <= rnd64;
         end
         if (cmd.out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      p1_a_sel_ff    <= cmd.a_sel;
      p1_b_sel_ff    <= cmd.b_sel;
      p1_to_minor_ff <= cmd.to_minor;
      p1_clr_ff      <= cmd.clr;
      p1_neg_ff      <= cmd.neg;
      p1_addr_a_ff   <= cmd.mat_addr_a;
      p1_addr_b_ff   <= cmd.mat_addr_b;

      prod_ff        <= opa * opb;
      p2_sh_ff       <= sh;
      p2_to_minor_ff <= p1_to_minor_ff;
      p2_clr_ff      <= p1_clr_ff;
      p2_neg_ff      <= p1_neg_ff;

      if (p2_valid_ff) begin
         if (p2_to_minor_ff) begin
            minor_ff <= (p2_clr_ff ? 64'd0 : minor_ff) + addend[63:0];
         end else begin
            acc_ff <= (p2_clr_ff ? 128'sd0 : acc_ff) + addend;
         end
      end

      if (cmd.div_start) begin
         rem_ff     <= '0;
         recip_ff   <= '0;
         div_cnt_ff <= '0;
      end else if (div_busy_ff) begin
         rem_ff     <= rem_d[63:0];
         recip_ff   <= {recip_ff[61:0], ge};
         div_cnt_ff <= div_cnt_ff + 6'd1;
      end

      if (cmd.out_load) begin
         out_row_ff   <= cmd.out_row;
         out_col_ff   <= cmd.out_col;
         out_last_ff  <= cmd.out_last;
         out_sing_ff  <= sts.singular;
         out_value_ff <= sts.singular ? 32'd0 : rndv;
         out_sat_ff   <= sts.singular ? 1'b0 : !fitsv;
      end
   end

   assign sts.div_busy = div_busy_ff;
   assign sts.singular = (det_ff == 64'sd0);
   assign sts.det_neg  = det_ff[63];
   assign sts.out_free = !out_valid_ff || rsp_ready;

   assign rsp_valid         = out_valid_ff;
   assign rsp_out_row       = out_row_ff;
   assign rsp_out_col       = out_col_ff;
   assign rsp_inverse_value = out_value_ff;
   assign rsp_singular      = out_sing_ff;
   assign rsp_saturated     = out_sat_ff;
   assign rsp_out_last      = out_last_ff;
endmodule

FILE: hdl/matrix4x4_inverse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix4x4_inverse: 4x4 fixed-point matrix inverse by the adjugate
// Loads Q16.16 elements one beat at a time and returns the sixteen inverse
// elements, row-major, after the beat flagged last.
// ----------------------------------------------------------------------------
// Usage:
//   req: one element per beat (row, col, element_value, last). Elements not
//        marked last are stored and give no result. Loading is possible only
//        while the block is idle; req.ready is low during a computation.
//   rsp: sixteen beats per inverse, out_last on the sixteenth. singular marks
//        a zero determinant (all values zero), saturated a clipped element.
//   Sequence: after the last element, the sixteen cofactors on the shared
//        multiplier, then the determinant, the reciprocal divider (one quotient
//        bit a cycle), then each output element (no multiply if singular).
//        The next matrix is not loaded until the whole inverse is through.
//   Stall: a full result register holds the sequencer on its round step;
//        once the sixteenth beat sits in the register, loading resumes.
//   Reset: the element store reads as the identity until written.
// ----------------------------------------------------------------------------
module matrix4x4_inverse (
   input  logic clock,
   input  logic reset,
   m4i_req_if.sink   req,
   m4i_rsp_if.source rsp
);
   import m4i_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   // sequencer: owns the step order and the load handshake
   m4i_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_last  (req.last),
      .req_ready (req.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // datapath: stores, multiplier, divider and result register
   m4i_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_row           (req.row),
      .req_col           (req.col),
      .req_element_value (req.element_value),
      .rsp_ready         (rsp.ready),
      .rsp_valid         (rsp.valid),
      .rsp_out_row       (rsp.out_row),
      .rsp_out_col       (rsp.out_col),
      .rsp_inverse_value (rsp.inverse_value),
      .rsp_singular      (rsp.singular),
      .rsp_saturated     (rsp.saturated),
      .rsp_out_last      (rsp.out_last)
   );
endmodule
